// File: hdl/spmf_pkg.sv
// Shared codes, field widths and controller command bundle for the
// strict priority multi-level queue. No dependencies.
package spmf_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned ItemW   = 16;
  localparam int unsigned StatusW = 2;

  typedef enum logic [KindW-1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_PEEK = 2'd2,
    KIND_NOP  = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // transaction accepted: run the queue operation
    logic load;     // read data is back: fill the output register
  } cmd_t;

endpackage

// File: hdl/spmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spmf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 80,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: hdl/spmf_ctrl.sv
// Controller state machine: handshakes on both channels and sequencing
// of the datapath. Depends on spmf_pkg.
module spmf_ctrl
  import spmf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_RESP);
  assign cmd_o.capture = in_valid_i && in_ready_o;
  assign cmd_o.load    = (state_q == ST_EXEC);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == ST_EXEC)
    else $error("capture not followed by execute");

  a_exec_to_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_o && !in_ready_o)
    else $error("execute not followed by response");

endmodule

// File: hdl/spmf_dp.sv
// Datapath: per-level pointers and fill counts, priority encoder, entry RAM
// and the output register. Depends on spmf_pkg and spmf_ram.
module spmf_dp
  import spmf_pkg::*;
#(
  parameter int unsigned LEVELS          = 5,
  parameter int unsigned DEPTH_PER_LEVEL = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [KindW-1:0]   kind_i,
  input  logic [LevelW-1:0]  level_i,
  input  logic [ItemW-1:0]   item_id_i,
  output logic [StatusW-1:0] status_o,
  output logic [ItemW-1:0]   out_item_o,
  output logic [LevelW-1:0]  out_level_o,
  output logic               level_empty_o,
  output logic               all_empty_o
);

  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned PW = $clog2(DEPTH_PER_LEVEL);
  localparam int unsigned CW = $clog2(DEPTH_PER_LEVEL + 1);
  localparam int unsigned NE = LEVELS * DEPTH_PER_LEVEL;
  localparam int unsigned AW = $clog2(NE);
  localparam int unsigned VW = 5;  // room to compare a level against LEVELS

  logic [LEVELS-1:0][CW-1:0] cnt_q;
  logic [LEVELS-1:0][PW-1:0] head_q;
  logic [LEVELS-1:0][PW-1:0] tail_q;

  logic             lvl_ok, full, lvl_empty, any_ne, hit, do_enq, do_deq;
  logic [LW-1:0]    lvl_idx, top;
  logic [PW-1:0]    tail_cur, head_cur;
  logic [AW-1:0]    waddr, raddr;
  logic [ItemW-1:0] rdata;
  status_e          status_d;

  logic             hit_q, lvl_empty_q;
  logic [LW-1:0]    top_q;
  status_e          status_q;

  function automatic logic [PW-1:0] wrap_next(logic [PW-1:0] p);
    return (p == PW'(DEPTH_PER_LEVEL - 1)) ? '0 : p + PW'(1);
  endfunction

  assign lvl_ok    = VW'(level_i) < VW'(LEVELS);
  assign lvl_idx   = LW'(level_i);
  assign full      = !lvl_ok || (cnt_q[lvl_idx] == CW'(DEPTH_PER_LEVEL));
  assign lvl_empty = !lvl_ok || (cnt_q[lvl_idx] == '0);

  // lowest-numbered non-empty level
  always_comb begin
    top    = '0;
    any_ne = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        top    = LW'(i);
        any_ne = 1'b1;
      end
    end
  end

  assign hit    = any_ne && (kind_i == KIND_DEQ || kind_i == KIND_PEEK);
  assign do_enq = cmd_i.capture && (kind_i == KIND_ENQ) && !full;
  assign do_deq = cmd_i.capture && (kind_i == KIND_DEQ) && any_ne;

  always_comb begin
    unique case (kind_e'(kind_i))
      KIND_ENQ:  status_d = full ? ST_FULL : ST_OK;
      KIND_DEQ,
      KIND_PEEK: status_d = any_ne ? ST_OK : ST_EMPTY;
      default:   status_d = ST_OK;
    endcase
  end

  assign tail_cur = tail_q[lvl_idx];
  assign head_cur = head_q[top];
  assign waddr    = AW'(lvl_idx) * AW'(DEPTH_PER_LEVEL) + AW'(tail_cur);
  assign raddr    = AW'(top) * AW'(DEPTH_PER_LEVEL) + AW'(head_cur);

  spmf_ram #(
    .WIDTH(ItemW),
    .DEPTH(NE)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (do_enq),
    .waddr_i(waddr),
    .wdata_i(item_id_i),
    .re_i   (cmd_i.capture && hit),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      head_q <= '0;
      tail_q <= '0;
    end else begin
      if (do_enq) begin
        cnt_q[lvl_idx]  <= cnt_q[lvl_idx] + CW'(1);
        tail_q[lvl_idx] <= wrap_next(tail_cur);
      end
      if (do_deq) begin
        cnt_q[top]  <= cnt_q[top] - CW'(1);
        head_q[top] <= wrap_next(head_cur);
      end
    end
  end

  // per-transaction state held for the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.capture) begin
      hit_q <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      top_q       <= top;
      lvl_empty_q <= lvl_empty;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_o      <= status_q;
      out_item_o    <= hit_q ? rdata : '0;
      out_level_o   <= hit_q ? LevelW'(top_q) : '0;
      level_empty_o <= lvl_empty_q;
      all_empty_o   <= (cnt_q == '0);
    end
  end

  a_hit_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && hit_q |-> status_q == ST_OK)
    else $error("item returned with a failing status");

  a_peek_keeps_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture && kind_i == KIND_PEEK |=> $stable(cnt_q))
    else $error("peek changed a fill count");

  a_no_capture_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !cmd_i.capture)
    else $error("new transaction taken while one executes");

endmodule

// File: hdl/strict_priority_multi_fifo.sv
// Strict priority multi-level queue: one FIFO per level, level 0 highest.
// Steps: capture of the input transaction, registered read of the shared entry
// RAM, then the result, held valid through any output stall; a new transaction is
// accepted only once the result has been taken.
// Reset clears all pointers and fill counts at once; no clearing pass.
// Depends on spmf_pkg, spmf_ctrl, spmf_dp and spmf_ram.
module strict_priority_multi_fifo
  import spmf_pkg::*;
#(
  parameter int unsigned LEVELS          = 5,
  parameter int unsigned DEPTH_PER_LEVEL = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [LevelW-1:0]  level_i,
  input  logic [ItemW-1:0]   item_id_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [ItemW-1:0]   out_item_o,
  output logic [LevelW-1:0]  out_level_o,
  output logic               level_empty_o,
  output logic               all_empty_o
);

  cmd_t cmd;

  spmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  spmf_dp #(
    .LEVELS         (LEVELS),
    .DEPTH_PER_LEVEL(DEPTH_PER_LEVEL)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_i       (kind_i),
    .level_i      (level_i),
    .item_id_i    (item_id_i),
    .status_o     (status_o),
    .out_item_o   (out_item_o),
    .out_level_o  (out_level_o),
    .level_empty_o(level_empty_o),
    .all_empty_o  (all_empty_o)
  );

endmodule

// File: tb/tb_strict_priority_multi_fifo.sv
// Self-checking testbench for strict_priority_multi_fifo: directed table, then
// biased random bursts under several idle patterns, checked by a queue predictor.
// Depends on spmf_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_strict_priority_multi_fifo;
  import spmf_pkg::*;

  localparam int unsigned NUM_LEVELS      = 5;
  localparam int unsigned LEVEL_DEPTH     = 16;
  localparam int unsigned ITEMS_PER_PHASE = 140;
  localparam int unsigned PRESSURE_ITEMS  = 40;
  localparam int unsigned HOLD_CYCLES     = 64;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned N_DIRECTED      = 13;

  typedef struct packed {
    status_e           status;
    logic [ItemW-1:0]  item;
    logic [LevelW-1:0] level;
    logic              level_empty;
    logic              all_empty;
  } queue_result_t;

  typedef struct {
    kind_e             kind;
    logic [LevelW-1:0] level;
    logic [ItemW-1:0]  item;
    int unsigned       burst_len;
    bit                typed;
    queue_result_t     result;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [KindW-1:0]   kind_i = '0;
  logic [LevelW-1:0]  level_i = '0;
  logic [ItemW-1:0]   item_id_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [ItemW-1:0]   out_item_o;
  logic [LevelW-1:0]  out_level_o;
  logic               level_empty_o;
  logic               all_empty_o;

  // predictor state, one FIFO per level
  logic [ItemW-1:0] slot_mem [NUM_LEVELS][LEVEL_DEPTH];
  int unsigned      rd_ptr   [NUM_LEVELS];
  int unsigned      wr_ptr   [NUM_LEVELS];
  int unsigned      fill_cnt [NUM_LEVELS];

  queue_result_t pending_results [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_full_seen = 0;
  int unsigned n_empty_seen = 0;
  int unsigned n_mismatches = 0;

  // expected results are typed in only where they are obvious
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{KIND_DEQ,  3'd0, 16'h0000,  1, 1'b1, '{ST_EMPTY, 16'h0000, 3'd0, 1'b1, 1'b1}},
    '{KIND_PEEK, 3'd7, 16'hFFFF,  1, 1'b1, '{ST_EMPTY, 16'h0000, 3'd0, 1'b1, 1'b1}},
    '{KIND_ENQ,  3'd5, 16'hFFFF,  1, 1'b1, '{ST_FULL,  16'h0000, 3'd0, 1'b1, 1'b1}},
    '{KIND_ENQ,  3'd7, 16'h0000,  1, 1'b1, '{ST_FULL,  16'h0000, 3'd0, 1'b1, 1'b1}},
    '{KIND_NOP,  3'd2, 16'h1234,  1, 1'b1, '{ST_OK,    16'h0000, 3'd0, 1'b1, 1'b1}},
    '{KIND_ENQ,  3'd4, 16'hFFFF,  1, 1'b1, '{ST_OK,    16'h0000, 3'd0, 1'b1, 1'b0}},
    '{KIND_PEEK, 3'd4, 16'h0000,  1, 1'b1, '{ST_OK,    16'hFFFF, 3'd4, 1'b0, 1'b0}},
    '{KIND_ENQ,  3'd0, 16'h0000,  1, 1'b1, '{ST_OK,    16'h0000, 3'd0, 1'b1, 1'b0}},
    '{KIND_ENQ,  3'd1, 16'h8000, 16, 1'b0, '0},
    '{KIND_ENQ,  3'd1, 16'h7FFF,  1, 1'b1, '{ST_FULL,  16'h0000, 3'd0, 1'b0, 1'b0}},
    '{KIND_DEQ,  3'd1, 16'h0000,  1, 1'b1, '{ST_OK,    16'h0000, 3'd0, 1'b0, 1'b0}},
    '{KIND_DEQ,  3'd0, 16'h5A5A,  1, 1'b0, '0},
    '{KIND_NOP,  3'd6, 16'hA5A5,  1, 1'b0, '0}
  };

  strict_priority_multi_fifo #(
    .LEVELS         (NUM_LEVELS),
    .DEPTH_PER_LEVEL(LEVEL_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .level_i      (level_i),
    .item_id_i    (item_id_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .out_item_o   (out_item_o),
    .out_level_o  (out_level_o),
    .level_empty_o(level_empty_o),
    .all_empty_o  (all_empty_o)
  );

  always #4 clk_i = ~clk_i;

  // Apply one operation to the predictor state and return its result.
  task automatic predict_queue_op(input kind_e k, input logic [LevelW-1:0] lvl,
                                  input logic [ItemW-1:0] id, output queue_result_t r);
    int unsigned top;
    bit          none_left;
    r = '0;
    r.status = ST_OK;
    r.level_empty = (lvl >= NUM_LEVELS) ? 1'b1 : (fill_cnt[lvl] == 0);
    case (k)
      KIND_ENQ: begin
        if (lvl >= NUM_LEVELS || fill_cnt[lvl] >= LEVEL_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot_mem[lvl][wr_ptr[lvl]] = id;
          wr_ptr[lvl] = (wr_ptr[lvl] + 1) % LEVEL_DEPTH;
          fill_cnt[lvl]++;
        end
      end
      KIND_DEQ, KIND_PEEK: begin
        top = NUM_LEVELS;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
          if (fill_cnt[i] != 0) top = i;
        end
        if (top == NUM_LEVELS) begin
          r.status = ST_EMPTY;
        end else begin
          r.item  = slot_mem[top][rd_ptr[top]];
          r.level = LevelW'(top);
          if (k == KIND_DEQ) begin
            rd_ptr[top] = (rd_ptr[top] + 1) % LEVEL_DEPTH;
            fill_cnt[top]--;
          end
        end
      end
      default: ;
    endcase
    none_left = 1'b1;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (fill_cnt[i] != 0) none_left = 1'b0;
    end
    r.all_empty = none_left;
  endtask

  // Offer one transaction and hold it until accepted; called at a rising edge.
  task automatic send_txn(input kind_e k, input logic [LevelW-1:0] lvl,
                          input logic [ItemW-1:0] id, input bit typed,
                          input queue_result_t typed_res);
    bit            fire;
    queue_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    level_i    <= lvl;
    item_id_i  <= id;
    do begin
      @(negedge clk_i);
      fire = in_valid_i && in_ready_o;
      @(posedge clk_i);
    end while (!fire);
    predict_queue_op(k, lvl, id, want);
    pending_results.push_back(typed ? typed_res : want);
    n_sent++;
  endtask

  initial begin : stimulus
    int unsigned   send_pct [5];
    int unsigned   recv_pct [5];
    int unsigned   burst_left;
    int unsigned   mode;
    int unsigned   roll;
    int unsigned   n_items;
    logic [LevelW-1:0] focus;
    logic [LevelW-1:0] lvl;
    kind_e         k;
    send_pct = '{0, 52, 0, 25, 0};
    recv_pct = '{0, 0, 52, 25, 0};
    burst_left = 0;
    mode = 0;
    focus = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      for (int j = 0; j < directed_rows[r].burst_len; j++) begin
        send_txn(directed_rows[r].kind, directed_rows[r].level,
                 directed_rows[r].item + ItemW'(j), directed_rows[r].typed,
                 directed_rows[r].result);
      end
    end

    // Random bursts: fill runs aimed at one level, drain runs, and noise.
    for (int p = 0; p < 5; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      n_items = ITEMS_PER_PHASE;
      if (p == 4) begin
        hold_request = 1'b1;
        n_items = PRESSURE_ITEMS;
      end
      for (int n = 0; n < n_items; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(24, 8);
          mode = $urandom_range(99);
          focus = LevelW'($urandom_range(NUM_LEVELS - 1));
        end
        burst_left--;
        roll = $urandom_range(99);
        if (mode < 45) begin
          k = (roll < 85) ? KIND_ENQ : ((roll < 95) ? KIND_DEQ : KIND_PEEK);
          lvl = ($urandom_range(3) == 0) ? LevelW'($urandom_range(NUM_LEVELS - 1)) : focus;
        end else if (mode < 75) begin
          k = (roll < 70) ? KIND_DEQ : ((roll < 90) ? KIND_PEEK : KIND_ENQ);
          lvl = LevelW'($urandom_range(7));
        end else begin
          k = kind_e'($urandom_range(3));
          lvl = LevelW'($urandom_range(7));
        end
        send_txn(k, lvl, ItemW'($urandom), 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d transactions in and %0d results checked,",
             n_sent, n_checked);
    $display("%0d full and %0d all-empty, idle on both sides plus one long hold-off.",
             n_full_seen, n_empty_seen);
    if (n_mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : result_side
    queue_result_t got;
    queue_result_t want;
    bit            fire;
    bit            bad;
    int unsigned   hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      fire = out_valid_o && out_ready_i;
      got  = '{status_e'(status_o), out_item_o, out_level_o, level_empty_o, all_empty_o};
      @(posedge clk_i);
      if (fire) begin
        if (pending_results.size() == 0) begin
          n_mismatches++;
          if (n_mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing pending: status=%0d item=%h level=%0d",
                     $realtime, got.status, got.item, got.level);
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (got.status == ST_FULL) n_full_seen++;
          if (got.status == ST_EMPTY) n_empty_seen++;
          bad = (got.status !== want.status) || (got.item !== want.item) ||
                (got.level !== want.level) || (got.level_empty !== want.level_empty) ||
                (got.all_empty !== want.all_empty);
          if (bad) begin
            n_mismatches++;
            if (n_mismatches <= MAX_REPORTS)
              $display({"%0t: mismatch exp st=%0d it=%h lv=%0d le=%0b ae=%0b,",
                        " got st=%0d it=%h lv=%0d le=%0b ae=%0b"},
                       $realtime, want.status, want.item, want.level, want.level_empty,
                       want.all_empty, got.status, got.item, got.level, got.level_empty,
                       got.all_empty);
          end
        end
      end
      // take the hold-off request once, then count it down here
      if (hold_request && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog: no transaction for %0d cycles", $realtime, quiet);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: strict_priority_multi_fifo.f
hdl/spmf_pkg.sv
hdl/spmf_ram.sv
hdl/spmf_ctrl.sv
hdl/spmf_dp.sv
hdl/strict_priority_multi_fifo.sv
tb/tb_strict_priority_multi_fifo.sv
